// ===== src/tta_pkg.sv =====
// Shared types and codes for the transaction-ID tag allocator.
// Depends on nothing; txid_tag_allocator_unit and tta_stack import it.
package tta_pkg;

    // Fixed field widths of the stream words
    localparam int TXID_W      = 8;
    localparam int IN_HANDLE_W = 32;
    localparam int ACT_W       = 2;
    localparam int STAT_W      = 2;

    // Action codes carried in s_axis_tuser
    localparam logic [ACT_W-1:0] ACT_ALLOC   = 2'd0;
    localparam logic [ACT_W-1:0] ACT_LOOKUP  = 2'd1;
    localparam logic [ACT_W-1:0] ACT_RELEASE = 2'd2;

    // Status codes carried in m_axis_tuser
    localparam logic [STAT_W-1:0] ST_DONE = 2'd0;
    localparam logic [STAT_W-1:0] ST_FULL = 2'd1;
    localparam logic [STAT_W-1:0] ST_BAD  = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR = 3'b001,
        S_IDLE  = 3'b010,
        S_EXEC  = 3'b100
    } state_t;

    // Commands from the controller to the free stack
    typedef struct packed {
        logic rd_en;   // read the top entry (issued when an allocate is taken)
        logic pop;     // commit a pop, growing first if the stack is empty
        logic push;    // commit a push of push_id
    } stack_cmd_t;

    // Status from the free stack to the controller
    typedef struct packed {
        logic empty;     // no free ID on the stack
        logic grow_ok;   // capacity can still double
    } stack_stat_t;

endpackage

// ===== src/txid_tag_allocator_unit.sv =====
// Top level of the transaction-ID tag allocator: stream ports, sequencer and slot table.
// Depends on tta_pkg, tta_ram and tta_stack.
//
//  channel  | dir | words                       | fields (lowest bit first)
//  ---------+-----+-----------------------------+-----------------------------------------
//  s_axis   | in  | one command per word        | tuser: action; tdata: handle, txid_in
//  m_axis   | out | one result per command word | tuser: status; tdata: txid_out, handle
//
//  A command is accepted and issues the slot and stack reads, then in S_EXEC it
//  modifies and writes back at most one slot entry and one stack entry. Both RAMs
//  have a registered read port; a command is taken only after the previous
//  write-back, so no forwarding. After reset a clearing pass writes zero to all
//  MAX_IDS slot entries, one per cycle, with s_axis_tready low until it ends.
//  A result waits in the output register; the next command is still accepted and
//  holds in its write-back cycle until that register is free.
module txid_tag_allocator_unit import tta_pkg::*; #(
    parameter int MAX_IDS     = 256,
    parameter int MIN_IDS     = 16,
    parameter int HANDLE_BITS = 32
) (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        s_axis_tvalid,
    output logic                        s_axis_tready,
    input  logic [IN_HANDLE_W+TXID_W-1:0] s_axis_tdata,  // session_handle, txid_in
    input  logic [ACT_W-1:0]            s_axis_tuser,  // action
    output logic                        m_axis_tvalid,
    input  logic                        m_axis_tready,
    output logic [TXID_W+IN_HANDLE_W-1:0] m_axis_tdata,  // txid_out, handle_out
    output logic [STAT_W-1:0]           m_axis_tuser   // status
);

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);
    localparam int CW    = (CNT_W > TXID_W) ? CNT_W : TXID_W;
    localparam logic [ID_W-1:0] LAST_ID = ID_W'(MAX_IDS - 1);

    state_t state_reg, state_next;

    // Captured command word
    logic [ACT_W-1:0]       act_reg;
    logic [IN_HANDLE_W-1:0] handle_reg;
    logic [TXID_W-1:0]      txid_reg;

    // Result register
    logic                   out_valid_reg, out_valid_next;
    logic [TXID_W-1:0]      out_txid_reg;
    logic [IN_HANDLE_W-1:0] out_handle_reg;
    logic [STAT_W-1:0]      out_status_reg;

    logic [ID_W-1:0]        clr_cnt_reg, clr_cnt_next;

    logic                   accept;
    logic                   commit;
    logic                   in_range;
    logic                   slot_nz;

    logic [HANDLE_BITS-1:0] slot_rdata;
    logic                   slot_we;
    logic [ID_W-1:0]        slot_waddr;
    logic [HANDLE_BITS-1:0] slot_wdata;

    // Write-back decisions of the current command
    logic                   res_we;
    logic [ID_W-1:0]        res_waddr;
    logic [HANDLE_BITS-1:0] res_wdata;
    logic [TXID_W-1:0]      res_txid;
    logic [IN_HANDLE_W-1:0] res_handle;
    logic [STAT_W-1:0]      res_status;

    stack_cmd_t             stk_cmd;
    stack_stat_t            stk_stat;
    logic [ID_W-1:0]        pop_id;
    logic [CNT_W-1:0]       capacity;

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept        = s_axis_tvalid && s_axis_tready;
    // Hold write-back while the previous result is still waiting
    assign commit        = (state_reg == S_EXEC) && (!out_valid_reg || m_axis_tready);

    assign in_range = (CW'(txid_reg) < CW'(capacity)) && (CW'(txid_reg) < CW'(MAX_IDS));
    assign slot_nz  = (slot_rdata != '0);

    always_comb
    begin
        res_we      = 1'b0;
        res_waddr   = ID_W'(txid_reg);
        res_wdata   = '0;
        res_txid    = txid_reg;
        res_handle  = '0;
        res_status  = ST_BAD;
        // Read the stack top as soon as an allocate is taken
        stk_cmd.rd_en = accept && (s_axis_tuser == ACT_ALLOC);
        stk_cmd.pop  = 1'b0;
        stk_cmd.push = 1'b0;
        case (act_reg)
            ACT_ALLOC:
            begin
                res_txid = '0;
                if (stk_stat.empty && !stk_stat.grow_ok)
                begin
                    res_status = ST_FULL;
                end
                else
                begin
                    stk_cmd.pop = commit;
                    res_we      = 1'b1;
                    res_waddr   = pop_id;
                    res_wdata   = HANDLE_BITS'(handle_reg);
                    res_txid    = TXID_W'(pop_id);
                    res_status  = ST_DONE;
                end
            end
            ACT_LOOKUP:
            begin
                if (in_range && slot_nz)
                begin
                    res_handle = IN_HANDLE_W'(slot_rdata);
                    res_status = ST_DONE;
                end
            end
            ACT_RELEASE:
            begin
                if (in_range && slot_nz)
                begin
                    res_we       = 1'b1;
                    stk_cmd.push = commit;
                    res_status   = ST_DONE;
                end
            end
            default:
            begin
                res_status = ST_BAD;
            end
        endcase
    end

    // Slot write port: clearing pass after reset, else command write-back
    always_comb
    begin
        if (state_reg == S_CLEAR)
        begin
            slot_we    = 1'b1;
            slot_waddr = clr_cnt_reg;
            slot_wdata = '0;
        end
        else
        begin
            slot_we    = commit && res_we;
            slot_waddr = res_waddr;
            slot_wdata = res_wdata;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        clr_cnt_next = clr_cnt_reg;
        case (state_reg)
            S_CLEAR:
            begin
                clr_cnt_next = clr_cnt_reg + ID_W'(1);
                if (clr_cnt_reg == LAST_ID)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                if (commit)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_CLEAR;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_axis_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_cnt_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_cnt_reg   <= clr_cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // Payload registers: capture on accept, load result on commit
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            act_reg    <= s_axis_tuser;
            handle_reg <= s_axis_tdata[IN_HANDLE_W-1:0];
            txid_reg   <= s_axis_tdata[IN_HANDLE_W +: TXID_W];
        end
        if (commit)
        begin
            out_txid_reg   <= res_txid;
            out_handle_reg <= res_handle;
            out_status_reg <= res_status;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {out_handle_reg, out_txid_reg};
    assign m_axis_tuser  = out_status_reg;

    tta_ram #(
        .WIDTH (HANDLE_BITS),
        .DEPTH (MAX_IDS)
    ) u_slot_ram (
        .clk   (clk),
        .we    (slot_we),
        .waddr (slot_waddr),
        .wdata (slot_wdata),
        .re    (accept),
        .raddr (ID_W'(s_axis_tdata[IN_HANDLE_W +: TXID_W])),
        .rdata (slot_rdata)
    );

    tta_stack #(
        .MAX_IDS (MAX_IDS),
        .MIN_IDS (MIN_IDS)
    ) u_stack (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (stk_cmd),
        .push_id  (ID_W'(txid_reg)),
        .stat     (stk_stat),
        .pop_id   (pop_id),
        .capacity (capacity)
    );

    a_no_accept_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_CLEAR |-> !s_axis_tready && !m_axis_tvalid)
        else $error("command taken or result shown during the clearing pass");

    a_accept_to_exec: assert property (@(posedge clk) disable iff (!rst_n)
        s_axis_tvalid && s_axis_tready |=> state_reg == S_EXEC)
        else $error("accepted command did not enter write-back");

    a_result_from_exec: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_axis_tvalid) |-> $past(state_reg == S_EXEC))
        else $error("result appeared without a write-back cycle");

    a_stack_cmd_excl: assert property (@(posedge clk) disable iff (!rst_n)
        (stk_cmd.pop || stk_cmd.push) |-> (commit && !(stk_cmd.pop && stk_cmd.push)))
        else $error("stack update outside a committed write-back");

endmodule

// ===== src/tta_ram.sv =====
// Generic single-write, single-read synchronous RAM with a registered read port.
// Depends on nothing.
module tta_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== src/tta_stack.sv =====
// LIFO free-ID stack: pointer, capacity, low-water mark and refill base registers over one RAM.
// Depends on tta_pkg and tta_ram.
module tta_stack import tta_pkg::*; #(
    parameter int MAX_IDS = 256,
    parameter int MIN_IDS = 16
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  stack_cmd_t                   cmd,
    input  logic [$clog2(MAX_IDS)-1:0]   push_id,
    output stack_stat_t                  stat,
    output logic [$clog2(MAX_IDS)-1:0]   pop_id,
    output logic [$clog2(MAX_IDS+1)-1:0] capacity
);

    localparam int ID_W  = $clog2(MAX_IDS);
    localparam int CNT_W = $clog2(MAX_IDS + 1);

    localparam logic [CNT_W-1:0] MIN_CNT = CNT_W'(MIN_IDS);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_IDS);
    localparam logic [CNT_W:0]   MAX_DBL = (CNT_W+1)'(MAX_IDS);

    // Entries below wm_reg still hold the refill pattern base_reg-1-pos and
    // were never written; entries from wm_reg up to ptr_reg live in the RAM.
    logic [CNT_W-1:0] ptr_reg,  ptr_next;
    logic [CNT_W-1:0] cap_reg,  cap_next;
    logic [CNT_W-1:0] wm_reg,   wm_next;
    logic [CNT_W-1:0] base_reg, base_next;

    logic [CNT_W-1:0] top_pos;
    logic [CNT_W-1:0] pushed_ptr;
    logic [CNT_W:0]   cap_dbl;
    logic [CNT_W-1:0] pattern_id;
    logic [ID_W-1:0]  ram_rdata;
    logic             ram_we;

    assign top_pos    = ptr_reg - CNT_W'(1);
    assign cap_dbl    = {cap_reg, 1'b0};
    assign pattern_id = base_reg - CNT_W'(1) - top_pos;
    assign stat.empty   = (ptr_reg == '0);
    assign stat.grow_ok = (cap_dbl <= MAX_DBL);
    assign capacity     = cap_reg;

    // On an empty stack the grown pattern yields the old capacity first
    always_comb
    begin
        if (stat.empty)
        begin
            pop_id = ID_W'(cap_reg);
        end
        else if (top_pos < wm_reg)
        begin
            pop_id = ID_W'(pattern_id);
        end
        else
        begin
            pop_id = ram_rdata;
        end
    end

    assign ram_we     = cmd.push && (ptr_reg < MAX_CNT);
    assign pushed_ptr = ram_we ? ptr_reg + CNT_W'(1) : ptr_reg;

    always_comb
    begin
        ptr_next  = ptr_reg;
        cap_next  = cap_reg;
        wm_next   = wm_reg;
        base_next = base_reg;
        if (cmd.pop)
        begin
            if (stat.empty)
            begin
                // grow, then pop the lowest new ID
                cap_next  = cap_dbl[CNT_W-1:0];
                base_next = cap_dbl[CNT_W-1:0];
                ptr_next  = cap_reg - CNT_W'(1);
                wm_next   = cap_reg - CNT_W'(1);
            end
            else
            begin
                ptr_next = top_pos;
                if (top_pos < wm_reg)
                begin
                    wm_next = top_pos;
                end
            end
        end
        else if (cmd.push)
        begin
            ptr_next = pushed_ptr;
            if (pushed_ptr == cap_reg && cap_reg > MIN_CNT)
            begin
                // every ID is back: shrink and restore the reset pattern
                cap_next  = MIN_CNT;
                ptr_next  = MIN_CNT;
                wm_next   = MIN_CNT;
                base_next = MIN_CNT;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ptr_reg  <= MIN_CNT;
            cap_reg  <= MIN_CNT;
            wm_reg   <= MIN_CNT;
            base_reg <= MIN_CNT;
        end
        else
        begin
            ptr_reg  <= ptr_next;
            cap_reg  <= cap_next;
            wm_reg   <= wm_next;
            base_reg <= base_next;
        end
    end

    tta_ram #(
        .WIDTH (ID_W),
        .DEPTH (MAX_IDS)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ID_W'(ptr_reg)),
        .wdata (push_id),
        .re    (cmd.rd_en),
        .raddr (ID_W'(top_pos)),
        .rdata (ram_rdata)
    );

    a_ptr_in_cap: assert property (@(posedge clk) disable iff (!rst_n)
        ptr_reg <= cap_reg)
        else $error("free stack holds more IDs than the capacity");

    a_wm_below_ptr: assert property (@(posedge clk) disable iff (!rst_n)
        wm_reg <= ptr_reg)
        else $error("low-water mark above the stack pointer");

    a_cap_range: assert property (@(posedge clk) disable iff (!rst_n)
        cap_reg >= MIN_CNT && cap_reg <= MAX_CNT && base_reg <= cap_reg)
        else $error("capacity or refill base out of range");

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for the transaction-ID tag allocator (txid_tag_allocator_unit).
// Depends on tta_pkg and the RTL under src; drives command words, predicts each reply
// with its own allocator model or takes it from the directed table, and checks every reply word field by field.
module tb;
    import tta_pkg::*;

    localparam int MAX_IDS     = 256;
    localparam int MIN_IDS     = 16;
    localparam int HANDLE_BITS = 32;

    // Spare action code: the block must answer it as a bad request
    localparam logic [ACT_W-1:0] ACT_SPARE = 2'd3;

    localparam int RAND_WORDS  = 1000;  // random command words after the directed table
    localparam int ZERO_TAIL   = 60;    // last words that may carry a zero handle
    localparam int CYCLE_LIMIT = 200000;
    localparam int DRAIN_WAIT  = 16;    // cycles to settle after the last reply
    localparam int QUIET_START = 2000;  // cycle window with no idling on either side
    localparam int QUIET_END   = 3500;

    typedef struct packed {
        logic [TXID_W-1:0]      txid;
        logic [IN_HANDLE_W-1:0] handle;
        logic [STAT_W-1:0]      status;
    } txid_result_t;

    // One directed command; typed = 1 means the reply below is checked as written,
    // otherwise the allocator model supplies it
    typedef struct packed {
        logic [ACT_W-1:0]       act;
        logic [IN_HANDLE_W-1:0] handle;
        logic [TXID_W-1:0]      txid;
        logic                   typed;
        txid_result_t           want;
    } dir_row_t;

    typedef enum logic [1:0] {
        MODE_FILL,
        MODE_DRAIN,
        MODE_CHURN
    } traffic_mode_t;

    localparam int DIR_ROWS = 16;
    localparam dir_row_t DIR_TABLE [0:DIR_ROWS-1] = '{
        // empty slot right after reset
        '{ACT_LOOKUP,  32'h0000_0000, 8'd0,   1'b1, '{8'd0,   32'h0000_0000, ST_BAD}},
        // allocate grants ID 0 first, then ID 1; extreme handles
        '{ACT_ALLOC,   32'hFFFF_FFFF, 8'd0,   1'b1, '{8'd0,   32'h0000_0000, ST_DONE}},
        '{ACT_LOOKUP,  32'h0000_0000, 8'd0,   1'b1, '{8'd0,   32'hFFFF_FFFF, ST_DONE}},
        '{ACT_ALLOC,   32'h0000_0001, 8'd77,  1'b1, '{8'd1,   32'h0000_0000, ST_DONE}},
        '{ACT_LOOKUP,  32'hFFFF_FFFF, 8'd1,   1'b1, '{8'd1,   32'h0000_0001, ST_DONE}},
        // out of range at the minimum capacity
        '{ACT_LOOKUP,  32'h0000_0000, 8'd255, 1'b1, '{8'd255, 32'h0000_0000, ST_BAD}},
        '{ACT_RELEASE, 32'h0000_0000, 8'd255, 1'b1, '{8'd255, 32'h0000_0000, ST_BAD}},
        '{ACT_RELEASE, 32'h0000_0000, 8'd16,  1'b1, '{8'd16,  32'h0000_0000, ST_BAD}},
        // release of an empty slot inside the range
        '{ACT_RELEASE, 32'h0000_0000, 8'd5,   1'b1, '{8'd5,   32'h0000_0000, ST_BAD}},
        // spare action code echoes the ID and changes nothing
        '{ACT_SPARE,   32'h5555_AAAA, 8'hAA,  1'b1, '{8'hAA,  32'h0000_0000, ST_BAD}},
        // release, release again, then reallocate: LIFO hands back ID 0
        '{ACT_RELEASE, 32'hAAAA_5555, 8'd0,   1'b1, '{8'd0,   32'h0000_0000, ST_DONE}},
        '{ACT_RELEASE, 32'h0000_0000, 8'd0,   1'b1, '{8'd0,   32'h0000_0000, ST_BAD}},
        '{ACT_ALLOC,   32'h1234_5678, 8'd0,   1'b1, '{8'd0,   32'h0000_0000, ST_DONE}},
        '{ACT_LOOKUP,  32'h0000_0000, 8'd15,  1'b1, '{8'd15,  32'h0000_0000, ST_BAD}},
        '{ACT_RELEASE, 32'h0000_0000, 8'd1,   1'b0, '{8'd0,   32'h0000_0000, ST_DONE}},
        '{ACT_LOOKUP,  32'h0000_0000, 8'd0,   1'b0, '{8'd0,   32'h0000_0000, ST_DONE}}
    };

    logic                          clk = 1'b0;
    logic                          rst_n = 1'b0;
    logic                          s_axis_tvalid = 1'b0;
    logic                          s_axis_tready;
    logic [IN_HANDLE_W+TXID_W-1:0] s_axis_tdata = '0;   // session_handle, txid_in
    logic [ACT_W-1:0]              s_axis_tuser = '0;   // action
    logic                          m_axis_tvalid;
    logic                          m_axis_tready = 1'b0;
    logic [TXID_W+IN_HANDLE_W-1:0] m_axis_tdata;        // txid_out, handle_out
    logic [STAT_W-1:0]             m_axis_tuser;        // status

    txid_tag_allocator_unit #(
        .MAX_IDS     (MAX_IDS),
        .MIN_IDS     (MIN_IDS),
        .HANDLE_BITS (HANDLE_BITS)
    ) dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #5 clk = ~clk;

    // ------------------------------------------------------------------
    // Allocator model: slot handles, LIFO of free IDs, live capacity
    // ------------------------------------------------------------------
    logic [IN_HANDLE_W-1:0] slot_handle [MAX_IDS];
    logic [TXID_W-1:0]      free_ids    [MAX_IDS];
    int                     free_top;
    int                     id_capacity;

    txid_result_t pending_results [$];   // replies owed by the block, oldest first

    int  cycles = 0;
    int  errors = 0;
    int  words_sent = 0;
    int  grow_count = 0;
    int  shrink_count = 0;
    int  full_count = 0;
    int  zero_allocs = 0;
    int  peak_capacity = MIN_IDS;
    bit  quiet;

    assign quiet = (cycles >= QUIET_START) && (cycles < QUIET_END);

    function automatic void free_push(input int id);
        if (free_top < MAX_IDS)
        begin
            free_ids[free_top] = id[TXID_W-1:0];
            free_top++;
        end
    endfunction

    // Restart from the minimum capacity: IDs MIN-1 down to 0, ID 0 on top
    function automatic void refill_to_min();
        free_top = 0;
        for (int i = MIN_IDS - 1; i >= 0; i--)
            free_push(i);
        id_capacity = MIN_IDS;
    endfunction

    function automatic void reset_allocator();
        for (int i = 0; i < MAX_IDS; i++)
        begin
            slot_handle[i] = '0;
            free_ids[i]    = '0;
        end
        refill_to_min();
    endfunction

    // Double the capacity; the new IDs go on so the lowest pops first
    function automatic bit grow_capacity();
        int doubled;
        doubled = id_capacity * 2;
        if (doubled > MAX_IDS)
            return 1'b0;
        for (int i = id_capacity; i < doubled; i++)
            slot_handle[i] = '0;
        for (int i = doubled - 1; i >= id_capacity; i--)
            free_push(i);
        id_capacity = doubled;
        grow_count++;
        if (id_capacity > peak_capacity)
            peak_capacity = id_capacity;
        return 1'b1;
    endfunction

    function automatic txid_result_t alloc_predict(input logic [ACT_W-1:0] act,
                                                   input logic [IN_HANDLE_W-1:0] handle,
                                                   input logic [TXID_W-1:0] txid);
        txid_result_t res;
        int           id;
        res.txid   = txid;
        res.handle = '0;
        res.status = ST_BAD;
        case (act)
            ACT_ALLOC:
            begin
                res.txid = '0;
                if (free_top == 0 && !grow_capacity())
                begin
                    res.status = ST_FULL;
                    full_count++;
                end
                else
                begin
                    free_top--;
                    id = int'(free_ids[free_top]);
                    slot_handle[id] = handle;
                    res.txid   = id[TXID_W-1:0];
                    res.status = ST_DONE;
                    if (handle == '0)
                        zero_allocs++;
                end
            end
            ACT_LOOKUP:
            begin
                if (int'(txid) < id_capacity && slot_handle[txid] != '0)
                begin
                    res.handle = slot_handle[txid];
                    res.status = ST_DONE;
                end
            end
            ACT_RELEASE:
            begin
                if (int'(txid) < id_capacity && slot_handle[txid] != '0)
                begin
                    slot_handle[txid] = '0;
                    free_push(int'(txid));
                    res.status = ST_DONE;
                    // every ID back home: shrink to the minimum and start over
                    if (free_top == id_capacity && id_capacity > MIN_IDS)
                    begin
                        for (int i = 0; i < MAX_IDS; i++)
                            slot_handle[i] = '0;
                        refill_to_min();
                        shrink_count++;
                    end
                end
            end
            default: ;
        endcase
        return res;
    endfunction

    // ------------------------------------------------------------------
    // Command side: idle at random, hold the word until tready, then
    // predict the reply at the accepting edge
    // ------------------------------------------------------------------
    task automatic send_command(input logic [ACT_W-1:0] act,
                                input logic [IN_HANDLE_W-1:0] handle,
                                input logic [TXID_W-1:0] txid,
                                input logic typed,
                                input txid_result_t want);
        txid_result_t pred;
        while (!quiet && $urandom_range(99) < 6)
        begin
            s_axis_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {txid, handle};
        s_axis_tuser  <= act;
        do
            @(posedge clk);
        while (!s_axis_tready);
        pred = alloc_predict(act, handle, txid);
        pending_results.push_back(typed ? want : pred);
        words_sent++;
    endtask

    // Find a slot that holds a session, starting at a random ID
    function automatic bit pick_live(output logic [TXID_W-1:0] txid);
        int start;
        int id;
        start = $urandom_range(id_capacity - 1);
        txid  = '0;
        for (int i = 0; i < id_capacity; i++)
        begin
            id = (start + i) % id_capacity;
            if (slot_handle[id] != '0)
            begin
                txid = id[TXID_W-1:0];
                return 1'b1;
            end
        end
        return 1'b0;
    endfunction

    // Nonzero handle, with the extremes mixed in; zero only near the end, since a
    // slot allocated with handle zero never comes back and blocks every shrink
    function automatic logic [IN_HANDLE_W-1:0] rand_handle(input bit allow_zero);
        logic [IN_HANDLE_W-1:0] h;
        int                     pick;
        pick = $urandom_range(99);
        h = $urandom;
        if (pick < 3)
            h = '1;
        else if (pick < 6)
            h = 32'd1;
        if (allow_zero && $urandom_range(5) == 0)
            h = '0;
        else if (h == '0)
            h = 32'd1;
        return h;
    endfunction

    // Shape the next random word around the current mode; roughly one word in
    // twelve is noise: any action code, any ID, any handle
    task automatic make_random(input traffic_mode_t mode, input bit allow_zero,
                               output logic [ACT_W-1:0] act,
                               output logic [IN_HANDLE_W-1:0] handle,
                               output logic [TXID_W-1:0] txid);
        int pick;
        bit live;
        pick   = $urandom_range(99);
        act    = ACT_ALLOC;
        handle = rand_handle(allow_zero);
        txid   = TXID_W'($urandom);
        if (pick >= 92)
        begin
            act    = ACT_W'($urandom);
            handle = $urandom;
        end
        else
        begin
            case (mode)
                MODE_FILL:  act = (pick < 78) ? ACT_ALLOC :
                                  (pick < 87) ? ACT_LOOKUP : ACT_RELEASE;
                MODE_DRAIN: act = (pick < 70) ? ACT_RELEASE :
                                  (pick < 84) ? ACT_LOOKUP : ACT_ALLOC;
                default:    act = (pick < 45) ? ACT_ALLOC :
                                  (pick < 78) ? ACT_RELEASE : ACT_LOOKUP;
            endcase
            // aim lookups and releases at live slots most of the time
            if (act != ACT_ALLOC && $urandom_range(9) < 8)
            begin
                live = pick_live(txid);
                if (!live && act == ACT_RELEASE)
                    act = ACT_ALLOC;
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Reply side: random backpressure, compare against the oldest prediction
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        cycles        <= cycles + 1;
        m_axis_tready <= quiet || ($urandom_range(99) >= 6);
    end

    always @(posedge clk)
    begin
        txid_result_t want;
        txid_result_t got;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            got.txid   = m_axis_tdata[TXID_W-1:0];
            got.handle = m_axis_tdata[TXID_W +: IN_HANDLE_W];
            got.status = m_axis_tuser;
            if (pending_results.size() == 0)
            begin
                $display("%0t: reply word with nothing outstanding: %s %0d %h %0d",
                         $time, "txid/handle/status", got.txid, got.handle, got.status);
                errors++;
            end
            else
            begin
                want = pending_results.pop_front();
                if (got.txid !== want.txid)
                begin
                    $display("%0t: txid_out expected %0d actual %0d",
                             $time, want.txid, got.txid);
                    errors++;
                end
                if (got.handle !== want.handle)
                begin
                    $display("%0t: handle_out expected %h actual %h",
                             $time, want.handle, got.handle);
                    errors++;
                end
                if (got.status !== want.status)
                begin
                    $display("%0t: status expected %0d actual %0d",
                             $time, want.status, got.status);
                    errors++;
                end
            end
        end
    end

    // Guard against a hung handshake
    always @(posedge clk)
    begin
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("timeout after %0d cycles, %0d replies outstanding",
                     cycles, pending_results.size());
            $display("FAILED: results differ");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Main sequence
    // ------------------------------------------------------------------
    initial
    begin
        logic [ACT_W-1:0]       act;
        logic [IN_HANDLE_W-1:0] handle;
        logic [TXID_W-1:0]      txid;
        traffic_mode_t          mode;
        int                     full_mark;
        int                     shrink_mark;
        int                     churn_left;
        txid_result_t           none;

        none = '0;
        reset_allocator();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;

        // directed table; the clearing pass after reset just shows up as tready low
        for (int r = 0; r < DIR_ROWS; r++)
            send_command(DIR_TABLE[r].act, DIR_TABLE[r].handle, DIR_TABLE[r].txid,
                         DIR_TABLE[r].typed, DIR_TABLE[r].want);

        // random traffic: fill to full capacity, drain until the shrink, churn at
        // the minimum, and around again
        mode        = MODE_FILL;
        full_mark   = full_count;
        shrink_mark = shrink_count;
        churn_left  = 0;
        for (int n = 0; n < RAND_WORDS; n++)
        begin
            make_random(mode, n >= RAND_WORDS - ZERO_TAIL, act, handle, txid);
            send_command(act, handle, txid, 1'b0, none);
            case (mode)
                MODE_FILL:
                    if (full_count - full_mark >= 3)
                    begin
                        mode        = MODE_DRAIN;
                        shrink_mark = shrink_count;
                    end
                MODE_DRAIN:
                    if (shrink_count != shrink_mark)
                    begin
                        mode       = MODE_CHURN;
                        churn_left = 60;
                    end
                default:
                begin
                    churn_left--;
                    if (churn_left <= 0)
                    begin
                        mode      = MODE_FILL;
                        full_mark = full_count;
                    end
                end
            endcase
        end
        s_axis_tvalid <= 1'b0;

        // drain the replies, then keep clocking so that a stray reply would show
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        $display("Ran %0d command words: %0d capacity doublings (peak %0d IDs), %0d shrinks,",
                 words_sent, grow_count, peak_capacity, shrink_count);
        $display("%0d full replies, %0d zero-handle grants, %0d mismatches.",
                 full_count, zero_allocs, errors);
        if (errors == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

endmodule
